### sv/mrpc_pkg.sv
`timescale 1ns / 1ps

package mrpc_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STG_IDLE,
    STG_WRITE,
    STG_READ
  } stage_t;

  localparam logic [1:0] CFG_X_FIRST = 2'd0;
  localparam logic [1:0] CFG_X_LAST  = 2'd1;
  localparam logic [1:0] CFG_Y_FIRST = 2'd2;
  localparam logic [1:0] CFG_Y_LAST  = 2'd3;

  localparam logic [6:0] X_FIRST_RST = 7'd0;
  localparam logic [6:0] X_LAST_RST  = 7'd127;
  localparam logic [5:0] Y_FIRST_RST = 6'd0;
  localparam logic [5:0] Y_LAST_RST  = 6'd63;

  typedef struct packed {
    logic [6:0] x_first;
    logic [6:0] x_last;
    logic [5:0] y_first;
    logic [5:0] y_last;
  } window_t;

  // one stored word: eight row bytes of one page, byte k is row 8p+k
  typedef logic [7:0][7:0] page_word_t;

endpackage

### sv/mrpc_win_mask.sv
`timescale 1ns / 1ps

module mrpc_win_mask #(
  parameter int WIDTH = 128
) (
  input  mrpc_pkg::window_t win,
  input  logic [5:0]        row,
  input  logic [3:0]        column_byte,
  input  logic [7:0]        pixels,
  output logic [7:0]        kept
);

  logic row_in;

  assign row_in = (row >= win.y_first) && (row <= win.y_last);

  always_comb begin
    logic [6:0] x;
    kept = '0;
    x    = '0;
    for (int b = 0; b < 8; b++) begin
      x = {column_byte, 3'(b)};
      // bit 7 of the byte is the leftmost pixel
      kept[7 - b] = pixels[7 - b] & row_in & (32'(x) < 32'(WIDTH)) &
                    (x >= win.x_first) & (x <= win.x_last);
    end
  end

endmodule

### sv/mono_row_to_page_converter_unit.sv
`timescale 1ns / 1ps

// channel  ports                                              handshake
// -------  -------------------------------------------------  -----------------------
// input    in_op in_row in_column_byte in_pixels in_page      start & !busy
//          in_column
// result   out_page_byte                                      out_valid, one cycle
// config   cfg_index cfg_wdata                                cfg_we, no wait
//
// in a write or read beat the page word is read from the frame memory, then written
// back with one row byte replaced or turned into a page byte. clear drops all
// per-word valid bits at once. busy is high in the cycle after an in-frame write
// or a read is accepted; the result shows up there and cannot be held. rst_n
// clears the valid bits and window registers, so no clearing pass is needed.

module mono_row_to_page_converter_unit #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_op,
  input  logic [5:0] in_row,
  input  logic [3:0] in_column_byte,
  input  logic [7:0] in_pixels,
  input  logic [2:0] in_page,
  input  logic [6:0] in_column,
  output logic       out_valid,
  output logic [7:0] out_page_byte,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata
);

  localparam int PAGES     = (HEIGHT + 7) / 8;
  localparam int ROW_BYTES = (WIDTH + 7) / 8;
  localparam int PAGE_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CB_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int ADDR_W    = PAGE_W + CB_W;
  localparam int DEPTH     = 1 << ADDR_W;

  mrpc_pkg::window_t  win_r;
  mrpc_pkg::stage_t   stg_r, stg_nxt;
  mrpc_pkg::op_t      op;

  logic               accept;
  logic               wr_ok, rd_ok, rd_zero;
  logic [ADDR_W-1:0]  acc_addr;
  logic [7:0]         kept;

  logic [ADDR_W-1:0]  addr_r;
  logic [2:0]         lane_r;
  logic [7:0]         kept_r;
  logic               rd_zero_r;

  mrpc_pkg::page_word_t mem_r [DEPTH];
  mrpc_pkg::page_word_t mem_q_r;
  mrpc_pkg::page_word_t old_word, new_word;
  logic [DEPTH-1:0]   valid_r;
  logic               valid_q_r;
  logic               mem_we;
  logic [7:0]         page_byte;

  assign op     = mrpc_pkg::op_t'(in_op);
  assign accept = start && !busy;

  // out-of-frame writes are dropped, out-of-frame reads give zero
  assign wr_ok   = (32'(in_row) < 32'(HEIGHT)) && (32'(in_column_byte) < 32'(ROW_BYTES));
  assign rd_zero = (32'(in_page) >= 32'(PAGES)) || (32'(in_column) >= 32'(WIDTH));
  assign rd_ok   = 1'b1;

  always_comb begin
    acc_addr = '0;
    case (op)
      mrpc_pkg::OP_WRITE: acc_addr = {PAGE_W'(in_row[5:3]), CB_W'(in_column_byte)};
      mrpc_pkg::OP_READ:  acc_addr = {PAGE_W'(in_page), CB_W'(in_column[6:3])};
      default:            acc_addr = '0;
    endcase
  end

  mrpc_win_mask #(
    .WIDTH (WIDTH)
  ) u_win_mask (
    .win         (win_r),
    .row         (in_row),
    .column_byte (in_column_byte),
    .pixels      (in_pixels),
    .kept        (kept)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.x_first <= mrpc_pkg::X_FIRST_RST;
      win_r.x_last  <= mrpc_pkg::X_LAST_RST;
      win_r.y_first <= mrpc_pkg::Y_FIRST_RST;
      win_r.y_last  <= mrpc_pkg::Y_LAST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mrpc_pkg::CFG_X_FIRST: win_r.x_first <= cfg_wdata;
        mrpc_pkg::CFG_X_LAST:  win_r.x_last  <= cfg_wdata;
        mrpc_pkg::CFG_Y_FIRST: win_r.y_first <= cfg_wdata[5:0];
        mrpc_pkg::CFG_Y_LAST:  win_r.y_last  <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // stage control
  always_comb begin
    stg_nxt = mrpc_pkg::STG_IDLE;
    case (stg_r)
      mrpc_pkg::STG_IDLE: begin
        if (accept && op == mrpc_pkg::OP_WRITE && wr_ok) begin
          stg_nxt = mrpc_pkg::STG_WRITE;
        end else if (accept && op == mrpc_pkg::OP_READ && rd_ok) begin
          stg_nxt = mrpc_pkg::STG_READ;
        end
      end
      default: stg_nxt = mrpc_pkg::STG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= mrpc_pkg::STG_IDLE;
    end else begin
      stg_r <= stg_nxt;
    end
  end

  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    mem_we    = 1'b0;
    case (stg_r)
      mrpc_pkg::STG_WRITE: begin
        busy   = 1'b1;
        mem_we = 1'b1;
      end
      mrpc_pkg::STG_READ: begin
        busy      = 1'b1;
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

  // beat fields registered on accept for the write-back or read stage
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r    <= acc_addr;
      lane_r    <= (op == mrpc_pkg::OP_WRITE) ? in_row[2:0] : in_column[2:0];
      kept_r    <= kept;
      rd_zero_r <= rd_zero;
    end
  end

  // frame memory: read on accept, write back in the next cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[addr_r] <= new_word;
    end
    if (accept) begin
      mem_q_r   <= mem_r[acc_addr];
      valid_q_r <= valid_r[acc_addr];
    end
  end

  // a word never written since clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (accept && op == mrpc_pkg::OP_CLEAR) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[addr_r] <= 1'b1;
    end
  end

  always_comb begin
    old_word = valid_q_r ? mem_q_r : '0;
    new_word = old_word;
    new_word[lane_r] = kept_r;
  end

  // pick one column out of each of the eight row bytes
  always_comb begin
    page_byte = '0;
    for (int k = 0; k < 8; k++) begin
      page_byte[k] = old_word[k][~lane_r];
    end
  end

  assign out_page_byte = rd_zero_r ? 8'd0 : page_byte;

  a_strobe_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside the second cycle of a beat");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == mrpc_pkg::OP_READ) |=> out_valid)
    else $error("accepted read beat gave no result");

  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == mrpc_pkg::OP_CLEAR) |=> (!out_valid && !busy))
    else $error("clear beat produced a result or went busy");

endmodule

### tb/mono_row_to_page_converter_unit_test.sv
`timescale 1ns / 1ps

module mono_row_to_page_converter_unit_test;

  localparam int FRAME_W       = 128;
  localparam int FRAME_H       = 64;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 1000;
  localparam int MAX_SHOWN     = 10;
  localparam int PHASE_BEATS   = 100;

  typedef struct {
    mrpc_pkg::op_t op;
    logic [5:0]    row;
    logic [3:0]    column_byte;
    logic [7:0]    pixels;
    logic [2:0]    page;
    logic [6:0]    column;
  } beat_t;

  typedef struct {
    beat_t      beat;
    bit         typed;
    logic [7:0] page_byte;
  } table_row_t;

  typedef struct {
    logic [7:0] page_byte;
    logic [2:0] page;
    logic [6:0] column;
  } page_read_t;

  logic          clk            = 1'b0;
  logic          rst_n          = 1'b0;
  logic          start          = 1'b0;
  logic          busy;
  mrpc_pkg::op_t in_op          = mrpc_pkg::OP_NONE;
  logic [5:0]    in_row         = '0;
  logic [3:0]    in_column_byte = '0;
  logic [7:0]    in_pixels      = '0;
  logic [2:0]    in_page        = '0;
  logic [6:0]    in_column      = '0;
  logic          out_valid;
  logic [7:0]    out_page_byte;
  logic          cfg_we         = 1'b0;
  logic [1:0]    cfg_index      = '0;
  logic [6:0]    cfg_wdata      = '0;

  // model of the frame store: frame_rows[y][x] is the pixel at row y, column x
  logic [FRAME_W-1:0] frame_rows [FRAME_H];
  mrpc_pkg::window_t  win;
  page_read_t         pending_page_bytes [$];
  table_row_t         directed_rows [$];
  int                 mismatches   = 0;
  int                 stall_cycles = 0;
  bit                 no_idle      = 1'b0;
  logic [5:0]         last_row     = '0;
  logic [3:0]         last_cb      = '0;
  page_read_t         oldest_read;

  mono_row_to_page_converter_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_row         (in_row),
    .in_column_byte (in_column_byte),
    .in_pixels      (in_pixels),
    .in_page        (in_page),
    .in_column      (in_column),
    .out_valid      (out_valid),
    .out_page_byte  (out_page_byte),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic note_mismatch(string line);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%s", line);
  endtask

  function automatic logic [7:0] page_byte_at(logic [2:0] p, logic [6:0] x);
    logic [7:0] v;
    for (int k = 0; k < 8; k++) v[k] = frame_rows[int'(p) * 8 + k][x];
    return v;
  endfunction

  function automatic void store_row_byte(logic [5:0] y, logic [3:0] cb, logic [7:0] px);
    int x;
    bit row_in;
    row_in = (y >= win.y_first) && (y <= win.y_last);
    for (int b = 0; b < 8; b++) begin
      x = int'(cb) * 8 + b;
      frame_rows[y][x] = row_in && (x >= win.x_first) && (x <= win.x_last) && px[7-b];
    end
  endfunction

  function automatic void clear_frame();
    foreach (frame_rows[i]) frame_rows[i] = '0;
  endfunction

  // update the model for one accepted beat and queue the page byte a read returns
  function automatic void predict_beat(beat_t b, bit typed, logic [7:0] typed_byte);
    page_read_t r;
    case (b.op)
      mrpc_pkg::OP_CLEAR: clear_frame();
      mrpc_pkg::OP_WRITE: store_row_byte(b.row, b.column_byte, b.pixels);
      mrpc_pkg::OP_READ: begin
        r.page      = b.page;
        r.column    = b.column;
        r.page_byte = typed ? typed_byte : page_byte_at(b.page, b.column);
        pending_page_bytes.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(beat_t b, bit typed, logic [7:0] typed_byte);
    int gap;
    start          <= 1'b1;
    in_op          <= b.op;
    in_row         <= b.row;
    in_column_byte <= b.column_byte;
    in_pixels      <= b.pixels;
    in_page        <= b.page;
    in_column      <= b.column;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_beat(b, typed, typed_byte);
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off new beats until every page byte is back, then let the pipe settle
  task automatic drain();
    start <= 1'b0;
    while (pending_page_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] index, logic [6:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    case (index)
      mrpc_pkg::CFG_X_FIRST: win.x_first = data;
      mrpc_pkg::CFG_X_LAST:  win.x_last  = data;
      mrpc_pkg::CFG_Y_FIRST: win.y_first = data[5:0];
      mrpc_pkg::CFG_Y_LAST:  win.y_last  = data[5:0];
      default: ;
    endcase
  endtask

  task automatic set_window(int xf, int xl, int yf, int yl);
    cfg_write(mrpc_pkg::CFG_X_FIRST, 7'(xf));
    cfg_write(mrpc_pkg::CFG_X_LAST, 7'(xl));
    cfg_write(mrpc_pkg::CFG_Y_FIRST, 7'(yf));
    cfg_write(mrpc_pkg::CFG_Y_LAST, 7'(yl));
    cfg_we <= 1'b0;
  endtask

  function automatic void add_row(mrpc_pkg::op_t op, int row, int cb, int px, int page,
                                  int col, bit typed = 1'b0, int page_byte = 0);
    table_row_t t;
    t.beat.op          = op;
    t.beat.row         = 6'(row);
    t.beat.column_byte = 4'(cb);
    t.beat.pixels      = 8'(px);
    t.beat.page        = 3'(page);
    t.beat.column      = 7'(col);
    t.typed            = typed;
    t.page_byte        = 8'(page_byte);
    directed_rows.push_back(t);
  endfunction

  // mostly writes and reads; reads often land on a recent write, writes often
  // inside the window, so page bytes carry real content
  function automatic beat_t random_beat();
    beat_t b;
    int roll;
    roll          = $urandom_range(0, 99);
    b.row         = 6'($urandom_range(0, 63));
    b.column_byte = 4'($urandom_range(0, 15));
    b.pixels      = 8'($urandom_range(0, 255));
    b.page        = 3'($urandom_range(0, 7));
    b.column      = 7'($urandom_range(0, 127));
    if (roll < 2) b.op = mrpc_pkg::OP_CLEAR;
    else if (roll < 6) b.op = mrpc_pkg::OP_NONE;
    else if (roll < 60) b.op = mrpc_pkg::OP_WRITE;
    else b.op = mrpc_pkg::OP_READ;
    if (b.op == mrpc_pkg::OP_WRITE) begin
      if (win.y_first <= win.y_last && $urandom_range(0, 1))
        b.row = 6'($urandom_range(win.y_first, win.y_last));
      if (win.x_first <= win.x_last && $urandom_range(0, 1))
        b.column_byte = 4'($urandom_range(win.x_first, win.x_last) >> 3);
      last_row = b.row;
      last_cb  = b.column_byte;
    end else if (b.op == mrpc_pkg::OP_READ && $urandom_range(0, 1)) begin
      b.page   = last_row[5:3];
      b.column = 7'(int'(last_cb) * 8 + $urandom_range(0, 7));
    end
    return b;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (i == count / 2 && $urandom_range(0, 1)) drain();
      send_beat(random_beat(), 1'b0, 8'h00);
    end
    drain();
  endtask

  task automatic random_window();
    int xf, xl, yf, yl, t;
    xf = $urandom_range(0, 127);
    xl = $urandom_range(0, 127);
    yf = $urandom_range(0, 63);
    yl = $urandom_range(0, 63);
    // keep most windows non-empty
    if ($urandom_range(0, 3) != 0) begin
      if (xf > xl) begin t = xf; xf = xl; xl = t; end
      if (yf > yl) begin t = yf; yf = yl; yl = t; end
    end
    set_window(xf, xl, yf, yl);
  endtask

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_page_bytes.size() == 0) begin
        note_mismatch($sformatf("page byte %02h with no read pending", out_page_byte));
      end else begin
        oldest_read = pending_page_bytes.pop_front();
        if (out_page_byte !== oldest_read.page_byte)
          note_mismatch($sformatf("page %0d column %0d: expected %02h, got %02h",
                                  oldest_read.page, oldest_read.column,
                                  oldest_read.page_byte, out_page_byte));
      end
    end
  end

  initial begin
    clear_frame();
    win.x_first = mrpc_pkg::X_FIRST_RST;
    win.x_last  = mrpc_pkg::X_LAST_RST;
    win.y_first = mrpc_pkg::Y_FIRST_RST;
    win.y_last  = mrpc_pkg::Y_LAST_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(mrpc_pkg::OP_READ,  0,  0, 8'h00, 0, 0,   1'b1, 8'h00);
    add_row(mrpc_pkg::OP_READ,  0,  0, 8'h00, 7, 127, 1'b1, 8'h00);
    add_row(mrpc_pkg::OP_WRITE, 0,  0, 8'h80, 0, 0);
    add_row(mrpc_pkg::OP_READ,  0,  0, 8'h00, 0, 0,   1'b1, 8'h01);
    add_row(mrpc_pkg::OP_WRITE, 63, 15, 8'h01, 0, 0);
    add_row(mrpc_pkg::OP_READ,  0,  0, 8'h00, 7, 127, 1'b1, 8'h80);
    add_row(mrpc_pkg::OP_WRITE, 7,  0, 8'hFF, 7, 127);
    add_row(mrpc_pkg::OP_READ,  63, 15, 8'hFF, 0, 0);
    add_row(mrpc_pkg::OP_READ,  0,  0, 8'h00, 0, 7);
    add_row(mrpc_pkg::OP_WRITE, 1,  0, 8'h55, 0, 0);
    add_row(mrpc_pkg::OP_WRITE, 2,  0, 8'hAA, 0, 0);
    add_row(mrpc_pkg::OP_READ,  0,  0, 8'h00, 0, 1);
    add_row(mrpc_pkg::OP_READ,  0,  0, 8'h00, 0, 2);
    add_row(mrpc_pkg::OP_NONE,  5,  3, 8'hFF, 0, 0);
    add_row(mrpc_pkg::OP_READ,  0,  0, 8'h00, 0, 0);
    add_row(mrpc_pkg::OP_WRITE, 63, 15, 8'hFF, 0, 0);
    add_row(mrpc_pkg::OP_READ,  0,  0, 8'h00, 7, 120);
    add_row(mrpc_pkg::OP_WRITE, 32, 8, 8'h3C, 0, 0);
    add_row(mrpc_pkg::OP_READ,  0,  0, 8'h00, 4, 66);
    add_row(mrpc_pkg::OP_WRITE, 7,  0, 8'h00, 0, 0);
    add_row(mrpc_pkg::OP_READ,  0,  0, 8'h00, 0, 0);
    add_row(mrpc_pkg::OP_CLEAR, 63, 15, 8'hFF, 7, 127);
    add_row(mrpc_pkg::OP_READ,  0,  0, 8'h00, 0, 0,   1'b1, 8'h00);
    add_row(mrpc_pkg::OP_READ,  0,  0, 8'h00, 7, 127, 1'b1, 8'h00);
    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].page_byte);
    drain();

    set_window(0, 127, 0, 63);
    run_random(PHASE_BEATS);
    // single pixel at the far corner, then at the origin
    set_window(127, 127, 63, 63);
    run_random(PHASE_BEATS);
    set_window(0, 0, 0, 0);
    run_random(PHASE_BEATS);
    // empty on one axis: every write stores zeros
    set_window(100, 20, 0, 63);
    run_random(PHASE_BEATS);
    set_window(0, 127, 40, 10);
    run_random(PHASE_BEATS);
    repeat (3) begin
      random_window();
      run_random(PHASE_BEATS);
    end

    if (mismatches == 0 && pending_page_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
